// ===== src/qrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned VAL_W  = 48;
  localparam int unsigned KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_REAL    = 2'd0,
    KIND_REPEAT  = 2'd1,
    KIND_COMPLEX = 2'd2,
    KIND_DEGEN   = 2'd3
  } kind_t;

endpackage

// ===== src/quadratic_root_solver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_core
// Pipelined solver for a*x^2 + b*x + c: exact discriminant, digit-by-digit
// square root and two restoring dividers, one stage per result bit.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit first)                   | tuser
//  in_     | slave     | coef_a, coef_b, coef_c (zero padded)    | -
//  out_    | master    | first_value, second_value               | root_kind
//
// One beat is accepted per cycle while the output is not stalled. Data passes
// through the input, product and discriminant registers, the one-bit-per-stage
// square root and divider chains and the output register. A stall on the output
// freezes the whole pipeline. Reset clears only the valid bits.
module quadratic_root_solver_core #(
  parameter int unsigned COEF_WIDTH = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // coef_a, coef_b, coef_c
  input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // first_value, second_value
  output logic [2*qrs_pkg::VAL_W-1:0] out_tdata,
  // root_kind
  output logic [qrs_pkg::KIND_W-1:0] out_tuser
);

  localparam int unsigned W    = COEF_WIDTH;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned DW   = 2*W + 2;
  localparam int unsigned NW   = DW + 2*F;
  localparam int unsigned RW   = NW / 2;
  localparam int unsigned NUMW = W + F + 3;
  localparam int unsigned QW   = NUMW - 1;
  localparam int unsigned OW   = qrs_pkg::VAL_W;
  localparam int unsigned CW   = ((QW > OW) ? QW : OW) + 1;

  typedef struct packed {
    qrs_pkg::kind_t          kind;
    logic signed [NUMW-1:0]  bneg;
    logic [W:0]              den;
    logic                    aneg;
  } ctx_t;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Input register.
  logic                v0_r;
  logic signed [W-1:0] a0_r, b0_r, c0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
    if (en) begin
      a0_r <= in_tdata[W-1:0];
      b0_r <= in_tdata[2*W-1:W];
      c0_r <= in_tdata[3*W-1:2*W];
    end
  end

  // Products.
  logic                  v1_r;
  logic signed [W-1:0]   a1_r, b1_r;
  logic signed [2*W-1:0] bb1_r, ac1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
    if (en) begin
      a1_r  <= a0_r;
      b1_r  <= b0_r;
      bb1_r <= b0_r * b0_r;
      ac1_r <= a0_r * c0_r;
    end
  end

  // Discriminant and square root front end.
  logic signed [DW-1:0] d_s;
  logic [DW-1:0]        dabs_s;
  logic [W-1:0]         aabs_s;
  ctx_t                 ctx_s;

  always_comb begin
    d_s    = DW'(bb1_r) - (DW'(ac1_r) <<< 2);
    dabs_s = d_s[DW-1] ? DW'(-d_s) : DW'(d_s);
    aabs_s = a1_r[W-1] ? W'(-a1_r) : W'(a1_r);
    ctx_s.aneg = a1_r[W-1];
    ctx_s.den  = {aabs_s, 1'b0};
    ctx_s.bneg = -(NUMW'(b1_r) <<< F);
    if (a1_r == '0) begin
      ctx_s.kind = qrs_pkg::KIND_DEGEN;
    end else if (d_s == '0) begin
      ctx_s.kind = qrs_pkg::KIND_REPEAT;
    end else if (d_s[DW-1]) begin
      ctx_s.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      ctx_s.kind = qrs_pkg::KIND_REAL;
    end
  end

  logic          sq_vld_r  [0:RW];
  logic [RW+1:0] sq_rem_r  [0:RW];
  logic [RW-1:0] sq_root_r [0:RW];
  logic [NW-1:0] sq_n_r    [0:RW];
  ctx_t          sq_ctx_r  [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= v1_r;
    end
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_n_r[0]    <= NW'(dabs_s) << (2*F);
      sq_ctx_r[0]  <= ctx_s;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RW+3:0] tmp;
    logic [RW+3:0] trial;
    logic          take;

    always_comb begin
      tmp   = {sq_rem_r[i], sq_n_r[i][NW-1:NW-2]};
      trial = (RW+4)'({sq_root_r[i], 2'b01});
      take  = tmp >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[i+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[i+1] <= sq_vld_r[i];
      end
      if (en) begin
        sq_rem_r[i+1]  <= take ? (RW+2)'(tmp - trial) : (RW+2)'(tmp);
        sq_root_r[i+1] <= {sq_root_r[i][RW-2:0], take};
        sq_n_r[i+1]    <= sq_n_r[i] << 2;
        sq_ctx_r[i+1]  <= sq_ctx_r[i];
      end
    end
  end

  // Numerators.
  logic signed [NUMW-1:0] sx_s, n1_s, n2_s;
  ctx_t                   cq_s;

  always_comb begin
    cq_s = sq_ctx_r[RW];
    sx_s = NUMW'(sq_root_r[RW]);
    case (cq_s.kind)
      qrs_pkg::KIND_REAL: begin
        n1_s = cq_s.bneg + sx_s;
        n2_s = cq_s.bneg - sx_s;
      end
      qrs_pkg::KIND_REPEAT: begin
        n1_s = cq_s.bneg;
        n2_s = cq_s.bneg;
      end
      qrs_pkg::KIND_COMPLEX: begin
        n1_s = cq_s.bneg;
        n2_s = sx_s;
      end
      default: begin
        n1_s = '0;
        n2_s = '0;
      end
    endcase
  end

  logic          dv_vld_r  [0:QW];
  logic [W:0]    dv_rem1_r [0:QW];
  logic [W:0]    dv_rem2_r [0:QW];
  logic [QW-1:0] dv_dq1_r  [0:QW];
  logic [QW-1:0] dv_dq2_r  [0:QW];
  logic          dv_sg1_r  [0:QW];
  logic          dv_sg2_r  [0:QW];
  ctx_t          dv_ctx_r  [0:QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[RW];
    end
    if (en) begin
      dv_rem1_r[0] <= '0;
      dv_rem2_r[0] <= '0;
      dv_dq1_r[0]  <= n1_s[NUMW-1] ? QW'(-n1_s) : QW'(n1_s);
      dv_dq2_r[0]  <= n2_s[NUMW-1] ? QW'(-n2_s) : QW'(n2_s);
      dv_sg1_r[0]  <= n1_s[NUMW-1] ^ cq_s.aneg;
      dv_sg2_r[0]  <= n2_s[NUMW-1] ^ cq_s.aneg;
      dv_ctx_r[0]  <= cq_s;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [W+1:0] t1, t2;
    logic         k1, k2;

    always_comb begin
      t1 = {dv_rem1_r[j], dv_dq1_r[j][QW-1]};
      t2 = {dv_rem2_r[j], dv_dq2_r[j][QW-1]};
      k1 = t1 >= (W+2)'(dv_ctx_r[j].den);
      k2 = t2 >= (W+2)'(dv_ctx_r[j].den);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j+1] <= dv_vld_r[j];
      end
      if (en) begin
        dv_rem1_r[j+1] <= k1 ? (W+1)'(t1 - (W+2)'(dv_ctx_r[j].den)) : (W+1)'(t1);
        dv_rem2_r[j+1] <= k2 ? (W+1)'(t2 - (W+2)'(dv_ctx_r[j].den)) : (W+1)'(t2);
        dv_dq1_r[j+1]  <= {dv_dq1_r[j][QW-2:0], k1};
        dv_dq2_r[j+1]  <= {dv_dq2_r[j][QW-2:0], k2};
        dv_sg1_r[j+1]  <= dv_sg1_r[j];
        dv_sg2_r[j+1]  <= dv_sg2_r[j];
        dv_ctx_r[j+1]  <= dv_ctx_r[j];
      end
    end
  end

  // Sign, saturation and output register.
  logic signed [CW-1:0] q1_s, q2_s;
  logic [OW-1:0]        f1_s, f2_s;
  logic                 out_vld_r;
  qrs_pkg::kind_t       kind_r;
  logic [OW-1:0]        first_r, second_r;

  localparam logic signed [CW-1:0] OUT_MAX = (CW'(1) <<< (OW-1)) - CW'(1);
  localparam logic signed [CW-1:0] OUT_MIN = -(CW'(1) <<< (OW-1));

  always_comb begin
    q1_s = dv_sg1_r[QW] ? -CW'(dv_dq1_r[QW]) : CW'(dv_dq1_r[QW]);
    q2_s = dv_sg2_r[QW] ? -CW'(dv_dq2_r[QW]) : CW'(dv_dq2_r[QW]);
    if (q1_s > OUT_MAX) begin
      f1_s = OW'(OUT_MAX);
    end else if (q1_s < OUT_MIN) begin
      f1_s = OW'(OUT_MIN);
    end else begin
      f1_s = OW'(q1_s);
    end
    if (q2_s > OUT_MAX) begin
      f2_s = OW'(OUT_MAX);
    end else if (q2_s < OUT_MIN) begin
      f2_s = OW'(OUT_MIN);
    end else begin
      f2_s = OW'(q2_s);
    end
    if (dv_ctx_r[QW].kind == qrs_pkg::KIND_DEGEN) begin
      f1_s = '0;
      f2_s = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[QW];
    end
    if (en) begin
      kind_r   <= dv_ctx_r[QW].kind;
      first_r  <= f1_s;
      second_r <= f2_s;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = kind_r;
  assign out_tdata  = {second_r, first_r};

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quadratic_root_solver_core. A table of directed
// coefficient sets and then random sets are streamed in with random gaps. The
// output side stalls at random. Every result beat is compared with a root
// prediction computed here per accepted beat, or with a table row's own roots.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int RANDOM_SETS = 830;
  localparam int DRAIN_CYCLES = 90;

  typedef struct packed {
    qrs_pkg::kind_t kind;
    logic [qrs_pkg::VAL_W-1:0] first;
    logic [qrs_pkg::VAL_W-1:0] second;
  } roots_t;

  typedef struct {
    logic [CW-1:0] a;
    logic [CW-1:0] b;
    logic [CW-1:0] c;
    bit typed;
    roots_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*qrs_pkg::VAL_W-1:0] out_tdata;
  logic [qrs_pkg::KIND_W-1:0] out_tuser;

  roots_t pending_roots[$];
  roots_t typed_roots[$];
  bit typed_flags[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  bit stim_done = 1'b0;

  quadratic_root_solver_core #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding.", pending_roots.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [qrs_pkg::VAL_W-1:0] floor_root(logic [63:0] n);
    logic [95:0] v;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    v = {n, 32'b0};
    rem = 0;
    root = 0;
    for (int i = 0; i < 32 + FB; i++) begin
      rem = (rem << 2) | v[95-2*i -: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root[qrs_pkg::VAL_W-1:0];
  endfunction

  function automatic logic [qrs_pkg::VAL_W-1:0] sat_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (q > 64'sd140737488355327) q = 64'sd140737488355327;
    if (q < -64'sd140737488355328) q = -64'sd140737488355328;
    return q[qrs_pkg::VAL_W-1:0];
  endfunction

  function automatic roots_t solve_roots(logic [CW-1:0] ra, logic [CW-1:0] rb,
                                         logic [CW-1:0] rc);
    roots_t r;
    longint a, b, c, disc, two_a, neg_b, root;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    c = longint'($signed(rc));
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_DEGEN;
      r.first = '0;
      r.second = '0;
      return r;
    end
    disc = b * b - 4 * a * c;
    two_a = 2 * a;
    neg_b = -b * (longint'(1) << FB);
    root = longint'(floor_root(disc < 0 ? -disc : disc));
    if (disc > 0) begin
      r.kind = qrs_pkg::KIND_REAL;
      r.first = sat_quot(neg_b + root, two_a);
      r.second = sat_quot(neg_b - root, two_a);
    end else if (disc == 0) begin
      r.kind = qrs_pkg::KIND_REPEAT;
      r.first = sat_quot(neg_b, two_a);
      r.second = r.first;
    end else begin
      r.kind = qrs_pkg::KIND_COMPLEX;
      r.first = sat_quot(neg_b, two_a);
      r.second = sat_quot(root, two_a);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [qrs_pkg::VAL_W-1:0] got,
                                 logic [qrs_pkg::VAL_W-1:0] want);
    errors++;
    $display("Mismatch on result %0d, %s: got %h, expected %h",
             beats_out, what, got, want);
  endtask

  always @(posedge clk) begin
    roots_t want;
    bit use_typed;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[qrs_pkg::VAL_W-1:0], '0);
      end else begin
        want = pending_roots.pop_front();
        use_typed = typed_flags.pop_front();
        if (use_typed) want = typed_roots.pop_front();
        if (out_tuser != want.kind)
          report_mismatch("root_kind", qrs_pkg::VAL_W'(out_tuser),
                          qrs_pkg::VAL_W'(want.kind));
        if (out_tdata[qrs_pkg::VAL_W-1:0] != want.first)
          report_mismatch("first_value", out_tdata[qrs_pkg::VAL_W-1:0], want.first);
        if (out_tdata[2*qrs_pkg::VAL_W-1:qrs_pkg::VAL_W] != want.second)
          report_mismatch("second_value", out_tdata[2*qrs_pkg::VAL_W-1:qrs_pkg::VAL_W],
                          want.second);
        kind_count[out_tuser]++;
      end
      beats_out++;
    end
  end

  always @(negedge clk) begin
    int stall;
    if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      case ($urandom_range(0, 99)) inside
        [0:69]: stall = 0;
        [70:94]: stall = $urandom_range(1, 3);
        default: stall = $urandom_range(10, 40);
      endcase
    end
  end

  task automatic send_coefs(logic [CW-1:0] a, logic [CW-1:0] b, logic [CW-1:0] c,
                            bit typed, roots_t want);
    int gap;
    case ($urandom_range(0, 99)) inside
      [0:69]: gap = 0;
      [70:94]: gap = $urandom_range(1, 3);
      default: gap = $urandom_range(10, 40);
    endcase
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {c, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_roots.push_back(solve_roots(a, b, c));
    typed_flags.push_back(typed);
    if (typed) typed_roots.push_back(want);
    beats_in++;
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_roots.size() != 0) @(negedge clk);
  endtask

  initial begin
    stim_row_t rows[$];
    logic [CW-1:0] a, b, c;
    int r, sel;
    rows = '{
      '{16'sd0, 16'sd5, 16'sd7, 1'b1, '{qrs_pkg::KIND_DEGEN, 48'd0, 48'd0}},
      '{16'sd0, 16'h8000, 16'h7FFF, 1'b1, '{qrs_pkg::KIND_DEGEN, 48'd0, 48'd0}},
      '{16'sd1, 16'sd0, 16'sd0, 1'b1, '{qrs_pkg::KIND_REPEAT, 48'd0, 48'd0}},
      '{16'sd1, 16'sd0, -16'sd1, 1'b1, '{qrs_pkg::KIND_REAL, 48'd65536, -48'sd65536}},
      '{16'sd1, 16'sd0, 16'sd1, 1'b1, '{qrs_pkg::KIND_COMPLEX, 48'd0, 48'd65536}},
      '{16'sd1, -16'sd2, 16'sd1, 1'b1, '{qrs_pkg::KIND_REPEAT, 48'd65536, 48'd65536}},
      '{-16'sd1, 16'sd0, 16'sd1, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{-16'sd1, 16'sd0, -16'sd1, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h8000, 16'h8000, 16'h7FFF, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h7FFF, 16'h8000, 16'h8000, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h7FFF, 16'h0000, 16'h7FFF, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'h8000, 16'h7FFF, 16'h0000, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'sd1, 16'h7FFF, 16'sd1, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'sd3, 16'sd5, 16'sd7, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{-16'sd3, 16'sd6, -16'sd3, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'sd2, -16'sd7, 16'sd3, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0}}
    };
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (rows[i]) send_coefs(rows[i].a, rows[i].b, rows[i].c, rows[i].typed,
                                 rows[i].want);
    // Drain fully once so the pipeline restarts from empty.
    wait_for_results();
    for (int n = 0; n < RANDOM_SETS; n++) begin
      sel = $urandom_range(0, 99);
      a = CW'($urandom);
      b = CW'($urandom);
      c = CW'($urandom);
      if (sel < 15) begin
        a = CW'($signed($urandom_range(0, 20)) - 10);
        b = CW'($signed($urandom_range(0, 40)) - 20);
        c = CW'($signed($urandom_range(0, 40)) - 20);
      end else if (sel < 30) begin
        // Repeated root: a*(x - r)^2.
        a = CW'($signed($urandom_range(0, 60)) - 30);
        r = $signed($urandom_range(0, 60)) - 30;
        b = CW'(-2 * $signed(a) * r);
        c = CW'($signed(a) * r * r);
      end else if (sel < 35) begin
        a = '0;
      end
      send_coefs(a, b, c, 1'b0, '{qrs_pkg::KIND_REAL, '0, '0});
    end
    wait_for_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d coefficient sets, received %0d results.", beats_in, beats_out);
    $display("Kinds seen: real %0d, repeated %0d, complex %0d, degenerate %0d.",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/qrs_pkg.sv
src/quadratic_root_solver_core.sv
sim/testbench.sv
